[src/csem_pkg.sv]
// ----------------------------------------------------------------------------
// csem_pkg
// Shared types and codes of the counting semaphore table: command and status
// codes, field widths and the packed request and result items.
// ----------------------------------------------------------------------------
package csem_pkg;

	localparam int CMD_W    = 2;
	localparam int SID_W    = 6;
	localparam int IVAL_W   = 16;
	localparam int REQ_W    = 5;
	localparam int STATUS_W = 2;
	localparam int NEWID_W  = 5;
	localparam int COUNT_W  = 15;

	localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_P      = 2'd1;
	localparam logic [CMD_W-1:0] CMD_V      = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ERR    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_QUEUED = 2'd2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7fff;

	typedef struct packed {
		logic [CMD_W-1:0]         command;
		logic [SID_W-1:0]         sem_id;
		logic signed [IVAL_W-1:0] init_value;
		logic [REQ_W-1:0]         requester;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [NEWID_W-1:0]  new_sem_id;
		logic                wake_valid;
		logic [REQ_W-1:0]    wake_requester;
	} out_item_t;

endpackage

[src/csem_ram.sv]
// ----------------------------------------------------------------------------
// csem_ram
// Simple dual-port synchronous memory: one write port, one read port, read
// data registered in the cycle after the address.
// ----------------------------------------------------------------------------
module csem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[src/counting_semaphore_table.sv]
// ----------------------------------------------------------------------------
// counting_semaphore_table
// Table of counting semaphores, each with a ring of waiting requesters.
// Per-semaphore state sits in an entry memory; waiter ids sit in a second
// memory addressed by semaphore and ring slot.
//
//   channel   handshake            payload
//   request   start & !busy        op     (csem_pkg::in_item_t)
//   result    done, one cycle      result (csem_pkg::out_item_t)
//
// An item goes through the entry memory read, then the update and write
// back. A V that wakes a waiter also needs the waiter memory read: the head
// slot is known only after the entry read, so it follows. The result strobe
// overlaps the next accept. Reset clears the created count and sequencer;
// memories are not cleared. The receiver cannot stall the block.
// ----------------------------------------------------------------------------
module counting_semaphore_table #(
	parameter int NUM_SEMS       = 32,
	parameter int QUEUE_DEPTH    = 16,
	parameter int NUM_REQUESTERS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  csem_pkg::in_item_t   op,
	output logic                 done,
	output csem_pkg::out_item_t  result
);

	localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int CW = $clog2(NUM_SEMS + 1);
	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int TW = $clog2(QUEUE_DEPTH + 1);
	localparam int WA = SW + QW;
	localparam int WDEPTH = NUM_SEMS * (1 << QW);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_WAKE = 2'd2;

	typedef struct packed {
		logic [csem_pkg::COUNT_W-1:0] count;
		logic [TW-1:0]                total;
		logic [QW-1:0]                head;
		logic [QW-1:0]                tail;
	} entry_t;

	localparam int EW = $bits(entry_t);

	function automatic logic [QW-1:0] next_slot(input logic [QW-1:0] q);
		next_slot = (32'(q) == QUEUE_DEPTH - 1) ? '0 : q + 1'b1;
	endfunction

	logic [1:0]                  state_q;
	logic [CW-1:0]               created_q;
	csem_pkg::in_item_t          op_q;
	logic                        done_q;
	csem_pkg::out_item_t         result_q;

	logic [SW+csem_pkg::SID_W-1:0] sid_in_ext;
	logic [SW+csem_pkg::SID_W-1:0] sid_q_ext;
	logic [CW+csem_pkg::NEWID_W-1:0] created_ext;
	logic [SW-1:0]               ent_raddr;
	logic [SW-1:0]               sid_addr;
	logic [EW-1:0]               ent_rbits;
	entry_t                      ent;
	entry_t                      ent_new;
	logic                        ent_we;
	logic [SW-1:0]               ent_waddr;
	logic                        wait_we;
	logic [WA-1:0]               wait_waddr;
	logic [WA-1:0]               wait_raddr;
	logic [csem_pkg::REQ_W-1:0]  wait_rdata;
	logic                        accept;
	logic                        sid_ok;
	logic                        req_ok;
	logic                        create_ok;
	logic                        go_wake;
	logic                        bump;
	csem_pkg::out_item_t         res_eval;

	assign accept      = start && (state_q == ST_IDLE);
	assign sid_in_ext  = {{SW{1'b0}}, op.sem_id};
	assign sid_q_ext   = {{SW{1'b0}}, op_q.sem_id};
	assign ent_raddr   = sid_in_ext[SW-1:0];
	assign sid_addr    = sid_q_ext[SW-1:0];
	assign created_ext = {{csem_pkg::NEWID_W{1'b0}}, created_q};
	assign ent         = entry_t'(ent_rbits);
	assign wait_raddr  = {sid_addr, ent.head};

	assign sid_ok    = 32'(op_q.sem_id) < 32'(created_q);
	assign req_ok    = 32'(op_q.requester) < NUM_REQUESTERS;
	assign create_ok = (32'(created_q) < NUM_SEMS) && !op_q.init_value[csem_pkg::IVAL_W-1];

	always_comb begin
		ent_new    = ent;
		ent_we     = 1'b0;
		ent_waddr  = sid_addr;
		wait_we    = 1'b0;
		wait_waddr = {sid_addr, ent.tail};
		go_wake    = 1'b0;
		bump       = 1'b0;
		res_eval   = '{status: csem_pkg::STATUS_ERR, new_sem_id: '0,
			wake_valid: 1'b0, wake_requester: '0};
		if (state_q == ST_EVAL) begin
			case (op_q.command)
				csem_pkg::CMD_CREATE: begin
					if (create_ok) begin
						ent_new.count = op_q.init_value[csem_pkg::COUNT_W-1:0];
						ent_new.total = '0;
						ent_new.head  = '0;
						ent_new.tail  = '0;
						ent_we        = 1'b1;
						ent_waddr     = created_q[SW-1:0];
						bump          = 1'b1;
						res_eval.status     = csem_pkg::STATUS_OK;
						res_eval.new_sem_id = created_ext[csem_pkg::NEWID_W-1:0];
					end
				end
				csem_pkg::CMD_P: begin
					if (sid_ok && req_ok) begin
						if (ent.count != '0) begin
							ent_new.count   = ent.count - 1'b1;
							ent_we          = 1'b1;
							res_eval.status = csem_pkg::STATUS_OK;
						end else if (32'(ent.total) < QUEUE_DEPTH) begin
							ent_new.tail    = next_slot(ent.tail);
							ent_new.total   = TW'(ent.total + 1'b1);
							ent_we          = 1'b1;
							wait_we         = 1'b1;
							res_eval.status = csem_pkg::STATUS_QUEUED;
						end
					end
				end
				csem_pkg::CMD_V: begin
					if (sid_ok) begin
						if (ent.total != '0) begin
							ent_new.head  = next_slot(ent.head);
							ent_new.total = TW'(ent.total - 1'b1);
							ent_we        = 1'b1;
							go_wake       = 1'b1;
						end else if (ent.count != csem_pkg::COUNT_MAX) begin
							ent_new.count   = ent.count + 1'b1;
							ent_we          = 1'b1;
							res_eval.status = csem_pkg::STATUS_OK;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	csem_ram #(
		.WIDTH(EW),
		.DEPTH(NUM_SEMS)
	) u_entry_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(ent_waddr),
		.wdata(EW'(ent_new)),
		.raddr(ent_raddr),
		.rdata(ent_rbits)
	);

	csem_ram #(
		.WIDTH(csem_pkg::REQ_W),
		.DEPTH(WDEPTH)
	) u_wait_ram (
		.clk  (clk),
		.we   (wait_we),
		.waddr(wait_waddr),
		.wdata(op_q.requester),
		.raddr(wait_raddr),
		.rdata(wait_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			created_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (bump) begin
						created_q <= created_q + 1'b1;
					end
					if (go_wake) begin
						state_q <= ST_WAKE;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_WAKE: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op;
		end
		if (state_q == ST_EVAL) begin
			result_q <= res_eval;
		end else if (state_q == ST_WAKE) begin
			result_q <= '{status: csem_pkg::STATUS_OK, new_sem_id: '0,
				wake_valid: 1'b1, wake_requester: wait_rdata};
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for counting_semaphore_table. A queue of pending items
// (a directed opening, then random create/P/V bursts and noise) feeds a driver
// that idles in short bursts. A monitor predicts the result of every
// accepted item from its own copy of the table and compares each result with
// the oldest expected one.
// ----------------------------------------------------------------------------
module testbench;

	localparam int NUM_SEMS       = 32;
	localparam int QUEUE_DEPTH    = 16;
	localparam int NUM_REQUESTERS = 32;
	localparam int ITEM_GOAL      = 1200;
	localparam int DRAIN_EVERY    = 250;
	localparam int QUIET_LIMIT    = 1000;

	typedef struct {
		csem_pkg::in_item_t op;
		bit                 drain;
	} pending_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	csem_pkg::in_item_t  op;
	logic                done;
	csem_pkg::out_item_t result;

	pending_t            pending_items[$];
	csem_pkg::out_item_t expected_results[$];

	bit  go;
	bit  taken;
	int  idle_left;
	int  accepted_count;
	int  total_items;
	int  quiet_cycles;
	int  fault_count;
	int  gen_made;

	// predicted table
	int                             sems_made;
	logic [csem_pkg::COUNT_W-1:0]   sem_level [NUM_SEMS];
	int                             waiter_cnt [NUM_SEMS];
	int                             ring_head  [NUM_SEMS];
	int                             ring_tail  [NUM_SEMS];
	logic [csem_pkg::REQ_W-1:0]     ring_slot [NUM_SEMS][QUEUE_DEPTH];

	counting_semaphore_table #(
		.NUM_SEMS      (NUM_SEMS),
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.NUM_REQUESTERS(NUM_REQUESTERS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.op    (op),
		.done  (done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic csem_pkg::out_item_t semaphore_outcome(input csem_pkg::in_item_t it);
		csem_pkg::out_item_t r;
		int s;
		r = '0;
		r.status = csem_pkg::STATUS_ERR;
		s = it.sem_id;
		case (it.command)
			csem_pkg::CMD_CREATE: begin
				if (sems_made < NUM_SEMS && !it.init_value[csem_pkg::IVAL_W-1]) begin
					sem_level[sems_made]  = it.init_value[csem_pkg::COUNT_W-1:0];
					waiter_cnt[sems_made] = 0;
					ring_head[sems_made]  = 0;
					ring_tail[sems_made]  = 0;
					r.new_sem_id = 5'(sems_made);
					sems_made++;
					r.status = csem_pkg::STATUS_OK;
				end
			end
			csem_pkg::CMD_P: begin
				if (s < sems_made && it.requester < NUM_REQUESTERS) begin
					if (sem_level[s] != '0) begin
						sem_level[s] = sem_level[s] - 1'b1;
						r.status = csem_pkg::STATUS_OK;
					end else if (waiter_cnt[s] < QUEUE_DEPTH) begin
						ring_slot[s][ring_tail[s]] = it.requester;
						ring_tail[s] = (ring_tail[s] + 1) % QUEUE_DEPTH;
						waiter_cnt[s]++;
						r.status = csem_pkg::STATUS_QUEUED;
					end
				end
			end
			csem_pkg::CMD_V: begin
				if (s < sems_made) begin
					if (waiter_cnt[s] > 0) begin
						r.wake_valid     = 1'b1;
						r.wake_requester = ring_slot[s][ring_head[s]];
						ring_head[s] = (ring_head[s] + 1) % QUEUE_DEPTH;
						waiter_cnt[s]--;
						r.status = csem_pkg::STATUS_OK;
					end else if (sem_level[s] != csem_pkg::COUNT_MAX) begin
						sem_level[s] = sem_level[s] + 1'b1;
						r.status = csem_pkg::STATUS_OK;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic csem_pkg::in_item_t random_item();
		csem_pkg::in_item_t it;
		it.command    = 2'($urandom_range(0, 3));
		it.sem_id     = 6'($urandom_range(0, 63));
		it.init_value = 16'($urandom_range(0, 16'hffff));
		it.requester  = 5'($urandom_range(0, 31));
		return it;
	endfunction

	function automatic csem_pkg::in_item_t make_item(
			input logic [csem_pkg::CMD_W-1:0] cmd, input int sid,
			input int ival, input int req);
		csem_pkg::in_item_t it;
		it = random_item();
		it.command = cmd;
		if (sid >= 0) it.sem_id = 6'(sid);
		if (ival >= 0) it.init_value = 16'(ival);
		if (req >= 0) it.requester = 5'(req);
		return it;
	endfunction

	function automatic int pick_sem();
		if (gen_made == 0 || $urandom_range(0, 15) == 0) return $urandom_range(0, 63);
		return $urandom_range(0, gen_made - 1);
	endfunction

	task automatic queue_item(input csem_pkg::in_item_t it);
		pending_t p;
		p.op    = it;
		p.drain = (total_items % DRAIN_EVERY == 0);
		pending_items.push_back(p);
		total_items++;
		if (it.command == csem_pkg::CMD_CREATE && !it.init_value[csem_pkg::IVAL_W-1]
				&& gen_made < NUM_SEMS)
			gen_made++;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			fault_count++;
			if (fault_count <= 10)
				$display("mismatch on %s: expected %0d, got %0d", name, want, got);
		end
	endtask

	// driver
	always @(negedge clk) begin : driver_blk
		pending_t nxt;
		if (go) begin
			if (start && !taken) begin
				// hold until accepted
			end else if (idle_left > 0) begin
				start <= 1'b0;
				op <= random_item();
				idle_left--;
			end else if (pending_items.size() == 0) begin
				start <= 1'b0;
			end else if (pending_items[0].drain && expected_results.size() != 0) begin
				start <= 1'b0;
			end else if (pending_items.size() > 150 && (pending_items.size() / 100) % 3 != 0
					&& $urandom_range(0, 3) == 0) begin
				start <= 1'b0;
				op <= random_item();
				idle_left = $urandom_range(1, 3) - 1;
			end else begin
				nxt = pending_items.pop_front();
				start <= 1'b1;
				op <= nxt.op;
			end
		end
	end

	// monitor
	always @(posedge clk) begin : monitor_blk
		csem_pkg::out_item_t want;
		if (arst_n) begin
			taken <= start && !busy;
			if (done) begin
				if (expected_results.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("result with nothing expected: status %0d", result.status);
				end else begin
					want = expected_results.pop_front();
					check_field("status", int'(want.status), int'(result.status));
					check_field("new_sem_id", int'(want.new_sem_id),
						int'(result.new_sem_id));
					check_field("wake_valid", int'(want.wake_valid),
						int'(result.wake_valid));
					check_field("wake_requester", int'(want.wake_requester),
						int'(result.wake_requester));
				end
			end
			if (start && !busy) begin
				expected_results.push_back(semaphore_outcome(op));
				accepted_count++;
			end
			if (start && !busy)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : main_blk
		int kind;
		int s;
		int n;
		csem_pkg::in_item_t it;
		arst_n = 1'b0;
		start  = 1'b0;
		op     = '0;
		go     = 1'b0;
		taken  = 1'b0;
		idle_left = 0;
		accepted_count = 0;
		total_items = 0;
		quiet_cycles = 0;
		fault_count = 0;
		gen_made = 0;
		sems_made = 0;

		// directed opening
		queue_item(make_item(csem_pkg::CMD_CREATE, -1, 16'hffff, -1));
		queue_item(make_item(csem_pkg::CMD_CREATE, -1, 16'h8000, -1));
		queue_item(make_item(csem_pkg::CMD_CREATE, -1, 0, -1));
		queue_item(make_item(csem_pkg::CMD_CREATE, -1, 16'h7fff, -1));
		queue_item(make_item(csem_pkg::CMD_P, 2, -1, 5));
		queue_item(make_item(csem_pkg::CMD_P, 0, -1, 31));
		queue_item(make_item(csem_pkg::CMD_P, 0, -1, 0));
		queue_item(make_item(csem_pkg::CMD_V, 1, -1, -1));
		queue_item(make_item(csem_pkg::CMD_V, 0, -1, -1));
		queue_item(make_item(csem_pkg::CMD_V, 0, -1, -1));
		queue_item(make_item(csem_pkg::CMD_V, 0, -1, -1));
		queue_item(make_item(csem_pkg::CMD_P, 0, -1, 7));
		queue_item(make_item(csem_pkg::CMD_P, 1, -1, 3));
		queue_item(make_item(csem_pkg::CMD_V, 1, -1, -1));
		queue_item(make_item(csem_pkg::CMD_V, 1, -1, -1));
		queue_item(make_item(csem_pkg::CMD_V, 63, -1, -1));
		queue_item(make_item(csem_pkg::CMD_P, 63, -1, 12));
		queue_item(make_item(2'd3, -1, -1, -1));
		queue_item(make_item(csem_pkg::CMD_CREATE, -1, 1, -1));

		// random bursts
		while (total_items < ITEM_GOAL) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				it = make_item(csem_pkg::CMD_CREATE, -1, -1, -1);
				case ($urandom_range(0, 5))
					0: ;
					1: it.init_value = 16'(16'h7fff - $urandom_range(0, 2));
					default: it.init_value = 16'($urandom_range(0, 3));
				endcase
				queue_item(it);
			end else if (kind <= 3) begin
				s = pick_sem();
				n = $urandom_range(1, 18);
				repeat (n) queue_item(make_item(csem_pkg::CMD_P, s, -1, -1));
			end else if (kind <= 6) begin
				s = pick_sem();
				n = $urandom_range(1, 18);
				repeat (n) queue_item(make_item(csem_pkg::CMD_V, s, -1, -1));
			end else if (kind <= 8) begin
				repeat (8) begin
					if ($urandom_range(0, 1) == 0)
						queue_item(make_item(csem_pkg::CMD_P, pick_sem(), -1, -1));
					else
						queue_item(make_item(csem_pkg::CMD_V, pick_sem(), -1, -1));
				end
			end else begin
				repeat ($urandom_range(1, 4)) queue_item(random_item());
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		go = 1'b1;

		while ((accepted_count < total_items || expected_results.size() != 0)
				&& quiet_cycles < QUIET_LIMIT)
			@(negedge clk);

		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
		end else begin
			repeat (8) @(negedge clk);
			if (expected_results.size() != 0)
				fault_count++;
			if (fault_count == 0)
				$display("Test completed successfully");
			else
				$display("Test completed with failures");
		end
		$finish;
	end

endmodule
